### rtl/core/srdr_pkg.sv
// Shared types and constants for the stick radial deadzone rescaler.
// Used by srdr_isqrt, srdr_div and stick_radial_deadzone_rescale.
package srdr_pkg;

    localparam int unsigned FULL_SCALE = 32767;
    localparam int unsigned DZ_MAX     = 32766;
    localparam int unsigned ROOT_STEPS = 16;
    localparam int unsigned QUO_BITS   = 15;
    localparam int unsigned SUM_W      = 32;
    localparam int unsigned NUM_W      = 47;
    localparam int unsigned DEN_W      = 31;

    localparam logic [1:0] REG_LEFT_DZ  = 2'd0;
    localparam logic [1:0] REG_RIGHT_DZ = 2'd1;

    typedef struct packed {
        logic        sx;
        logic        sy;
        logic [15:0] ax;
        logic [15:0] ay;
        logic [14:0] dz;
    } root_side_t;

    typedef struct packed {
        logic sx;
        logic sy;
        logic dead;
    } div_side_t;

endpackage

### rtl/core/srdr_isqrt.sv
// Pipelined floor square root, one result bit per stage.
// Depends on srdr_pkg.
module srdr_isqrt
    import srdr_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [SUM_W-1:0] in_n,
    input  root_side_t       in_side,
    output logic             out_valid,
    output logic [15:0]      out_root,
    output root_side_t       out_side
);

    logic             valid_reg [ROOT_STEPS];
    logic [SUM_W-1:0] n_reg     [ROOT_STEPS];
    logic [SUM_W-1:0] root_reg  [ROOT_STEPS];
    root_side_t       side_reg  [ROOT_STEPS];

    for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_step
        localparam logic [SUM_W:0] BIT = (SUM_W+1)'(1) << (30 - 2 * j);
        logic             v_in;
        logic [SUM_W-1:0] n_in;
        logic [SUM_W-1:0] r_in;
        root_side_t       s_in;
        logic [SUM_W:0]   trial;
        logic [SUM_W-1:0] n_next;
        logic [SUM_W-1:0] root_next;

        if (j == 0) begin : g_first
            assign v_in = in_valid;
            assign n_in = in_n;
            assign r_in = '0;
            assign s_in = in_side;
        end else begin : g_rest
            assign v_in = valid_reg[j-1];
            assign n_in = n_reg[j-1];
            assign r_in = root_reg[j-1];
            assign s_in = side_reg[j-1];
        end

        always_comb begin
            trial = {1'b0, r_in} + BIT;
            if ({1'b0, n_in} >= trial) begin
                n_next    = SUM_W'({1'b0, n_in} - trial);
                root_next = SUM_W'({1'b0, r_in >> 1} + BIT);
            end else begin
                n_next    = n_in;
                root_next = r_in >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[j] <= 1'b0;
            end else if (en) begin
                valid_reg[j] <= v_in;
            end
            if (en) begin
                n_reg[j]    <= n_next;
                root_reg[j] <= root_next;
                side_reg[j] <= s_in;
            end
        end
    end

    assign out_valid = valid_reg[ROOT_STEPS-1];
    assign out_root  = root_reg[ROOT_STEPS-1][15:0];
    assign out_side  = side_reg[ROOT_STEPS-1];

endmodule

### rtl/core/srdr_div.sv
// Pipelined restoring divider for both axes against one divisor.
// Saturation check in the first stage, then one quotient bit per stage. Depends on srdr_pkg.
module srdr_div
    import srdr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [NUM_W-1:0]    in_num_x,
    input  logic [NUM_W-1:0]    in_num_y,
    input  logic [DEN_W-1:0]    in_den,
    input  div_side_t           in_side,
    output logic                out_valid,
    output logic [QUO_BITS-1:0] out_q_x,
    output logic [QUO_BITS-1:0] out_q_y,
    output logic                out_sat_x,
    output logic                out_sat_y,
    output div_side_t           out_side
);

    localparam int unsigned STAGES = QUO_BITS + 1;

    logic                valid_reg [STAGES];
    logic [NUM_W-1:0]    rx_reg    [STAGES];
    logic [NUM_W-1:0]    ry_reg    [STAGES];
    logic [QUO_BITS-1:0] qx_reg    [STAGES];
    logic [QUO_BITS-1:0] qy_reg    [STAGES];
    logic                satx_reg  [STAGES];
    logic                saty_reg  [STAGES];
    logic [DEN_W-1:0]    den_reg   [STAGES];
    div_side_t           side_reg  [STAGES];

    for (genvar j = 0; j < STAGES; j++) begin : g_step
        logic [NUM_W-1:0]    rx_next;
        logic [NUM_W-1:0]    ry_next;
        logic [QUO_BITS-1:0] qx_next;
        logic [QUO_BITS-1:0] qy_next;
        logic                satx_next;
        logic                saty_next;
        logic                v_in;
        logic [DEN_W-1:0]    d_in;
        div_side_t           s_in;

        if (j == 0) begin : g_first
            logic [NUM_W-1:0] lim;
            assign v_in = in_valid;
            assign d_in = in_den;
            assign s_in = in_side;
            assign lim  = NUM_W'(in_den) << QUO_BITS;
            always_comb begin
                satx_next = in_num_x >= lim;
                saty_next = in_num_y >= lim;
                rx_next   = in_num_x;
                ry_next   = in_num_y;
                qx_next   = '0;
                qy_next   = '0;
            end
        end else begin : g_rest
            localparam int unsigned BI = QUO_BITS - j;
            logic [NUM_W-1:0] trial;
            assign v_in  = valid_reg[j-1];
            assign d_in  = den_reg[j-1];
            assign s_in  = side_reg[j-1];
            assign trial = NUM_W'(den_reg[j-1]) << BI;
            always_comb begin
                satx_next = satx_reg[j-1];
                saty_next = saty_reg[j-1];
                rx_next   = rx_reg[j-1];
                ry_next   = ry_reg[j-1];
                qx_next   = qx_reg[j-1];
                qy_next   = qy_reg[j-1];
                if (rx_reg[j-1] >= trial) begin
                    rx_next     = rx_reg[j-1] - trial;
                    qx_next[BI] = 1'b1;
                end
                if (ry_reg[j-1] >= trial) begin
                    ry_next     = ry_reg[j-1] - trial;
                    qy_next[BI] = 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[j] <= 1'b0;
            end else if (en) begin
                valid_reg[j] <= v_in;
            end
            if (en) begin
                rx_reg[j]   <= rx_next;
                ry_reg[j]   <= ry_next;
                qx_reg[j]   <= qx_next;
                qy_reg[j]   <= qy_next;
                satx_reg[j] <= satx_next;
                saty_reg[j] <= saty_next;
                den_reg[j]  <= d_in;
                side_reg[j] <= s_in;
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_q_x   = qx_reg[STAGES-1];
    assign out_q_y   = qy_reg[STAGES-1];
    assign out_sat_x = satx_reg[STAGES-1];
    assign out_sat_y = saty_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule

### rtl/core/stick_radial_deadzone_rescale.sv
// Scaled radial deadzone for thumbstick samples: top level.
// Depends on srdr_pkg, srdr_isqrt and srdr_div.
//
// Takes one sample per cycle while s_tready is high and returns one result per
// sample. The path runs through the 16-stage square root and the 16-stage
// divider. A result waiting at the output
// does not stop intake: a skid stage behind the output register holds one more,
// and only when it fills does s_tready drop. The deadzone registers are written
// through the cfg port, which is always ready; write them only while idle.
module stick_radial_deadzone_rescale
    import srdr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // stick_x[15:0], stick_y[31:16]
    input  logic        s_tuser,   // use_right
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_x[15:0], out_y[31:16]
    output logic        m_tuser    // in_deadzone
);

    logic [14:0] left_dz_reg;
    logic [14:0] right_dz_reg;
    logic        en;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_dz_reg  <= 15'd7849;
            right_dz_reg <= 15'd8689;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_LEFT_DZ:  left_dz_reg  <= cfg_data;
                REG_RIGHT_DZ: right_dz_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage A: magnitudes and deadzone select
    logic        a_valid_reg;
    root_side_t  a_side_reg;
    root_side_t  a_side_next;
    logic [15:0] sx_in;
    logic [15:0] sy_in;
    logic [14:0] dz_sel;

    always_comb begin
        sx_in  = s_tdata[15:0];
        sy_in  = s_tdata[31:16];
        dz_sel = s_tuser ? right_dz_reg : left_dz_reg;
        a_side_next.sx = sx_in[15];
        a_side_next.sy = sy_in[15];
        a_side_next.ax = sx_in[15] ? 16'(-sx_in) : sx_in;
        a_side_next.ay = sy_in[15] ? 16'(-sy_in) : sy_in;
        a_side_next.dz = (dz_sel > 15'(DZ_MAX)) ? 15'(DZ_MAX) : dz_sel;
    end

    // stage B: squares; stage C: sum
    logic             b_valid_reg;
    logic [31:0]      b_sqx_reg;
    logic [31:0]      b_sqy_reg;
    root_side_t       b_side_reg;
    logic             c_valid_reg;
    logic [SUM_W-1:0] c_sum_reg;
    root_side_t       c_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_tvalid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
        if (en) begin
            a_side_reg <= a_side_next;
            b_sqx_reg  <= a_side_reg.ax * a_side_reg.ax;
            b_sqy_reg  <= a_side_reg.ay * a_side_reg.ay;
            b_side_reg <= a_side_reg;
            c_sum_reg  <= b_sqx_reg + b_sqy_reg;
            c_side_reg <= b_side_reg;
        end
    end

    logic        r_valid;
    logic [15:0] r_root;
    root_side_t  r_side;

    srdr_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (c_valid_reg),
        .in_n      (c_sum_reg),
        .in_side   (c_side_reg),
        .out_valid (r_valid),
        .out_root  (r_root),
        .out_side  (r_side)
    );

    // stage D: deadzone test and differences
    logic        d_valid_reg;
    logic [15:0] d_diff_reg;
    logic [14:0] d_span_reg;
    logic [15:0] d_len_reg;
    logic [15:0] d_ax_reg;
    logic [15:0] d_ay_reg;
    div_side_t   d_side_reg;

    // stage E: products; stage F: numerators
    logic             e_valid_reg;
    logic [31:0]      e_px_reg;
    logic [31:0]      e_py_reg;
    logic [DEN_W-1:0] e_den_reg;
    div_side_t        e_side_reg;
    logic             f_valid_reg;
    logic [NUM_W-1:0] f_numx_reg;
    logic [NUM_W-1:0] f_numy_reg;
    logic [DEN_W-1:0] f_den_reg;
    div_side_t        f_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end else if (en) begin
            d_valid_reg <= r_valid;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= e_valid_reg;
        end
        if (en) begin
            d_diff_reg      <= r_root - {1'b0, r_side.dz};
            d_span_reg      <= 15'(FULL_SCALE) - r_side.dz;
            d_len_reg       <= r_root;
            d_ax_reg        <= r_side.ax;
            d_ay_reg        <= r_side.ay;
            d_side_reg.sx   <= r_side.sx;
            d_side_reg.sy   <= r_side.sy;
            d_side_reg.dead <= r_root <= {1'b0, r_side.dz};
            e_px_reg        <= d_ax_reg * d_diff_reg;
            e_py_reg        <= d_ay_reg * d_diff_reg;
            e_den_reg       <= d_len_reg * d_span_reg;
            e_side_reg      <= d_side_reg;
            f_numx_reg      <= (NUM_W'(e_px_reg) << 15) - NUM_W'(e_px_reg);
            f_numy_reg      <= (NUM_W'(e_py_reg) << 15) - NUM_W'(e_py_reg);
            f_den_reg       <= e_den_reg;
            f_side_reg      <= e_side_reg;
        end
    end

    logic                q_valid;
    logic [QUO_BITS-1:0] q_x;
    logic [QUO_BITS-1:0] q_y;
    logic                q_sat_x;
    logic                q_sat_y;
    div_side_t           q_side;

    srdr_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid_reg),
        .in_num_x  (f_numx_reg),
        .in_num_y  (f_numy_reg),
        .in_den    (f_den_reg),
        .in_side   (f_side_reg),
        .out_valid (q_valid),
        .out_q_x   (q_x),
        .out_q_y   (q_y),
        .out_sat_x (q_sat_x),
        .out_sat_y (q_sat_y),
        .out_side  (q_side)
    );

    // result formatting
    logic [15:0] mag_x;
    logic [15:0] mag_y;
    logic [15:0] res_x;
    logic [15:0] res_y;

    always_comb begin
        mag_x = q_sat_x ? 16'(FULL_SCALE) : {1'b0, q_x};
        mag_y = q_sat_y ? 16'(FULL_SCALE) : {1'b0, q_y};
        res_x = q_side.sx ? 16'(-mag_x) : mag_x;
        res_y = q_side.sy ? 16'(-mag_y) : mag_y;
        if (q_side.dead) begin
            res_x = '0;
            res_y = '0;
        end
    end

    // output register with skid stage
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic        out_dead_reg;
    logic        skid_valid_reg;
    logic [31:0] skid_data_reg;
    logic        skid_dead_reg;

    assign en = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                out_data_reg   <= skid_data_reg;
                out_dead_reg   <= skid_dead_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (out_valid_reg && !m_tready) begin
            if (q_valid) begin
                skid_data_reg  <= {res_y, res_x};
                skid_dead_reg  <= q_side.dead;
                skid_valid_reg <= 1'b1;
            end
        end else begin
            out_valid_reg <= q_valid;
            if (q_valid) begin
                out_data_reg <= {res_y, res_x};
                out_dead_reg <= q_side.dead;
            end
        end
    end

    assign s_tready = en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_dead_reg;

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds data while output register is empty");

    a_skid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && !m_tready |=> skid_valid_reg)
        else $error("skid data dropped during stall");

    a_dead_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 32'd0)
        else $error("deadzone result not zero");

    a_no_min_x: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:0] != 16'h8000 && m_tdata[31:16] != 16'h8000)
        else $error("result beyond negative full scale");

endmodule
